// ===== hdl/nlip_pkg.sv =====
package nlip_pkg;

  // Line protocol constants.
  localparam logic [15:0] OP_START = 16'h0609;
  localparam logic [15:0] OP_CONT  = 16'h0414;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  NEWLINE  = 8'h0A;

  // Decoded value of a text character: 0..63 alphabet, then pad, then invalid.
  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd65;

  // Result queue depth; one character can produce up to three results.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;
  localparam int unsigned RQ_CNT_W = 3;
  localparam int unsigned MAX_RES  = 3;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_OPCODE = 3'd1,
    CAUSE_ORPHAN = 3'd2,
    CAUSE_SHORT  = 3'd3,
    CAUSE_LONG   = 3'd4,
    CAUSE_CRC    = 3'd5,
    CAUSE_B64    = 3'd6
  } cause_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    cause_e      cause;
    logic        last;
  } res_t;

  // Up to three results written into the queue in the same cycle.
  typedef struct packed {
    logic [1:0]  cnt;
    res_t [2:0]  res;
  } push_t;

  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] s;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s = 7'd62;
    end else if (c == 8'h2F) begin
      s = 7'd63;
    end else if (c == 8'h3D) begin
      s = SEXTET_PAD;
    end else begin
      s = SEXTET_BAD;
    end
    return s;
  endfunction

  // CRC-16 with polynomial 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/nlip_res_fifo.sv =====
module nlip_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nlip_pkg::push_t      push_i,
  input  logic                 pop_i,
  output nlip_pkg::res_t       head_o,
  output logic                 valid_o,
  output logic                 room_o
);

  nlip_pkg::res_t                       mem_q [nlip_pkg::RQ_DEPTH];
  logic [nlip_pkg::RQ_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [nlip_pkg::RQ_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [nlip_pkg::RQ_CNT_W-1:0]        count_q, count_d;
  logic [nlip_pkg::RQ_CNT_W-1:0]        after_pop;
  logic                                 pop;

  assign valid_o   = (count_q != '0);
  assign pop       = pop_i && valid_o;
  assign head_o    = mem_q[rd_ptr_q];
  assign after_pop = count_q - nlip_pkg::RQ_CNT_W'(pop);
  // Room means a full group of three results fits after this cycle's pop.
  assign room_o    = (after_pop <=
                      nlip_pkg::RQ_CNT_W'(nlip_pkg::RQ_DEPTH - nlip_pkg::MAX_RES));

  assign rd_ptr_d = rd_ptr_q + nlip_pkg::RQ_PTR_W'(pop);
  assign wr_ptr_d = wr_ptr_q + nlip_pkg::RQ_PTR_W'(push_i.cnt);
  assign count_d  = after_pop + nlip_pkg::RQ_CNT_W'(push_i.cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < nlip_pkg::MAX_RES; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wr_ptr_q + nlip_pkg::RQ_PTR_W'(i)] <= push_i.res[i];
      end
    end
  end

endmodule

// ===== hdl/nlip_frame_receiver.sv =====
// Line-framed receiver for base64 packets protected by CRC-16/XMODEM. Feed it the
// received UART characters on the slave stream, one per transaction; a newline ends
// a line. Each line begins with two raw opcode bytes, 0x06 0x09 to open a frame or
// 0x04 0x14 to continue it, followed by base64 text. The first two decoded bytes of
// a frame give its big-endian length L; the next L-2 decoded bytes come out as
// payload results (tuser = 0) as soon as they are decoded, and the two bytes after
// them are the CRC. The newline of the line that completes L+2 bytes yields a
// verdict: accepted (tuser = 1) when the CRC over the L bytes that follow the length
// field leaves zero, else rejected (tuser = 2) with cause 5. Any framing or text
// error rejects the frame at the next newline with its cause in tdata; payload
// already delivered for a rejected frame must be dropped by the consumer. tlast
// marks the final result that a given character produced. Rate: one character per
// clock cycle while the result queue has room; each character is registered first.
// A character produces at most three results (a completed base64 group) and they
// leave at one per cycle while tready is high, through a four-entry result queue;
// the input stalls only while that queue lacks room for a full group of three, so
// the output side sets the sustained rate when it is slow.
module nlip_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] payload_byte, [10:8] reject_cause, rest 0
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last
);

  // Frame offset reaches L+2, which is at most BUFFER_BYTES.
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
  // Line position stops at BUFFER_BYTES-1.
  localparam int unsigned PW = $clog2(BUFFER_BYTES);

  typedef struct packed {
    logic [FW-1:0]    fo;
    logic [15:0]      len;
    logic [15:0]      crc;
    nlip_pkg::cause_e err;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic emit;
  } dec_t;

  // One decoded byte entering the frame: header, payload or CRC byte.
  function automatic dec_t take_dec(st_t s, logic start, logic [7:0] b);
    dec_t        r;
    logic [15:0] len1;
    logic [16:0] lim;
    r.st = s;
    r.emit = 1'b0;
    len1 = {s.len[15:8], b};
    lim = {1'b0, s.len} + 17'd2;
    if (s.err != nlip_pkg::CAUSE_NONE) begin
      r.st = s;
    end else if (s.fo == '0 && !start) begin
      r.st = s;
    end else if (s.fo == '0) begin
      r.st.len = {b, 8'h00};
      r.st.fo = FW'(1);
    end else if (s.fo == FW'(1)) begin
      r.st.len = len1;
      if (len1 < 16'd2) begin
        r.st.err = nlip_pkg::CAUSE_SHORT;
      end else if (({1'b0, len1} + 17'd2) > 17'(BUFFER_BYTES)) begin
        r.st.err = nlip_pkg::CAUSE_LONG;
      end else begin
        r.st.fo = FW'(2);
      end
    end else if (17'(s.fo) >= lim) begin
      r.st.err = nlip_pkg::CAUSE_LONG;
    end else begin
      r.st.crc = nlip_pkg::crc_byte(s.crc, b);
      r.emit = (17'(s.fo) < {1'b0, s.len});
      r.st.fo = s.fo + FW'(1);
    end
    return r;
  endfunction

  // Input register.
  logic [7:0]  in_q;
  logic        in_vld_q;
  logic        advance;
  logic        room;

  // Line and frame state.
  st_t         st_q, st_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]  ophi_q, ophi_d;
  logic        start_q, start_d;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  pad_q, pad_d;

  nlip_pkg::push_t push;
  nlip_pkg::res_t  head;
  logic            head_vld;

  assign advance         = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= s_axis_tdata_i;
    end
  end

  always_comb begin
    logic [6:0]       s6;
    logic [5:0]       sv;
    logic [1:0]       pad_n;
    logic [1:0]       ncnt;
    logic [23:0]      word;
    logic [15:0]      op;
    dec_t             d0, d1, d2;
    nlip_pkg::cause_e e;
    nlip_pkg::res_t [2:0] res;
    logic [1:0]       nres;

    st_d    = st_q;
    pos_d   = pos_q;
    ophi_d  = ophi_q;
    start_d = start_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    res     = '0;
    nres    = 2'd0;
    e       = st_q.err;

    s6    = nlip_pkg::sextet_of(in_q);
    pad_n = pad_q + 2'((s6 == nlip_pkg::SEXTET_PAD));
    sv    = (s6 == nlip_pkg::SEXTET_PAD) ? 6'd0 : s6[5:0];
    word  = {acc_q, sv};
    ncnt  = 2'd3 - pad_n;
    op    = {ophi_q, in_q};
    // The three bytes of a group go through the frame logic one after another.
    d0 = take_dec(st_q, start_q, word[23:16]);
    d1 = take_dec(d0.st, start_q, word[15:8]);
    d2 = take_dec(d1.st, start_q, word[7:0]);

    if (in_q == nlip_pkg::NEWLINE) begin
      if (e == nlip_pkg::CAUSE_NONE) begin
        if (pos_q < PW'(2)) begin
          e = nlip_pkg::CAUSE_OPCODE;
        end else if (cnt_q != 2'd0) begin
          e = nlip_pkg::CAUSE_B64;
        end else if (start_q && st_q.fo < FW'(2)) begin
          e = nlip_pkg::CAUSE_SHORT;
        end
      end
      if (e != nlip_pkg::CAUSE_NONE) begin
        res[0] = '{kind: nlip_pkg::KIND_REJECT, data: 8'h00, cause: e, last: 1'b0};
        nres = 2'd1;
        st_d.fo = '0;
        st_d.len = '0;
        st_d.crc = '0;
      end else if (st_q.fo >= FW'(2) && 17'(st_q.fo) == ({1'b0, st_q.len} + 17'd2)) begin
        if (st_q.crc == 16'h0000) begin
          res[0] = '{kind: nlip_pkg::KIND_ACCEPT, data: 8'h00,
                     cause: nlip_pkg::CAUSE_NONE, last: 1'b0};
        end else begin
          res[0] = '{kind: nlip_pkg::KIND_REJECT, data: 8'h00,
                     cause: nlip_pkg::CAUSE_CRC, last: 1'b0};
        end
        nres = 2'd1;
        st_d.fo = '0;
        st_d.len = '0;
        st_d.crc = '0;
      end
      st_d.err = nlip_pkg::CAUSE_NONE;
      pos_d    = '0;
      ophi_d   = 8'h00;
      start_d  = 1'b0;
      acc_d    = '0;
      cnt_d    = 2'd0;
      pad_d    = 2'd0;
    end else if (pos_q >= PW'(BUFFER_BYTES - 1)) begin
      // Line overrun: the position stops counting and the line is spoiled.
      if (st_q.err == nlip_pkg::CAUSE_NONE) begin
        st_d.err = nlip_pkg::CAUSE_B64;
      end
    end else begin
      pos_d = pos_q + PW'(1);
      if (st_q.err != nlip_pkg::CAUSE_NONE) begin
        // Rest of an errored line is ignored.
        pos_d = pos_q + PW'(1);
      end else if (pos_q == '0) begin
        ophi_d = in_q;
      end else if (pos_q == PW'(1)) begin
        if (op == nlip_pkg::OP_START) begin
          // A new start supersedes an open frame, which is rejected at once.
          if (st_q.fo != '0) begin
            res[0] = '{kind: nlip_pkg::KIND_REJECT, data: 8'h00,
                       cause: nlip_pkg::CAUSE_SHORT, last: 1'b0};
            nres = 2'd1;
          end
          st_d.fo = '0;
          st_d.len = '0;
          st_d.crc = '0;
          start_d = 1'b1;
        end else if (op == nlip_pkg::OP_CONT) begin
          if (st_q.fo == '0) begin
            st_d.err = nlip_pkg::CAUSE_ORPHAN;
          end
        end else begin
          st_d.err = nlip_pkg::CAUSE_OPCODE;
        end
      end else if (s6 == nlip_pkg::SEXTET_BAD) begin
        st_d.err = nlip_pkg::CAUSE_B64;
      end else if (pad_q != 2'd0 && cnt_q == 2'd0) begin
        // Nothing may follow a padded group.
        st_d.err = nlip_pkg::CAUSE_B64;
      end else if (s6 == nlip_pkg::SEXTET_PAD && cnt_q < 2'd2) begin
        st_d.err = nlip_pkg::CAUSE_B64;
      end else if (s6 != nlip_pkg::SEXTET_PAD && pad_q != 2'd0) begin
        st_d.err = nlip_pkg::CAUSE_B64;
      end else if (cnt_q == 2'd3) begin
        pad_d = pad_n;
        acc_d = '0;
        cnt_d = 2'd0;
        if (ncnt == 2'd3) begin
          st_d = d2.st;
        end else if (ncnt == 2'd2) begin
          st_d = d1.st;
        end else begin
          st_d = d0.st;
        end
        if (d0.emit) begin
          res[nres] = '{kind: nlip_pkg::KIND_DATA, data: word[23:16],
                        cause: nlip_pkg::CAUSE_NONE, last: 1'b0};
          nres = nres + 2'd1;
        end
        if (d1.emit && ncnt >= 2'd2) begin
          res[nres] = '{kind: nlip_pkg::KIND_DATA, data: word[15:8],
                        cause: nlip_pkg::CAUSE_NONE, last: 1'b0};
          nres = nres + 2'd1;
        end
        if (d2.emit && ncnt == 2'd3) begin
          res[nres] = '{kind: nlip_pkg::KIND_DATA, data: word[7:0],
                        cause: nlip_pkg::CAUSE_NONE, last: 1'b0};
          nres = nres + 2'd1;
        end
      end else begin
        pad_d = pad_n;
        acc_d = {acc_q[11:0], sv};
        cnt_d = cnt_q + 2'd1;
      end
    end

    if (nres != 2'd0) begin
      res[nres - 2'd1].last = 1'b1;
    end
    push.res = res;
    push.cnt = advance ? nres : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '{fo: '0, len: '0, crc: '0, err: nlip_pkg::CAUSE_NONE};
      pos_q   <= '0;
      ophi_q  <= '0;
      start_q <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
      pad_q   <= '0;
    end else if (advance) begin
      st_q    <= st_d;
      pos_q   <= pos_d;
      ophi_q  <= ophi_d;
      start_q <= start_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
    end
  end

  // Result queue decouples the one-per-cycle output from bursts of three results.
  nlip_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready_i),
    .head_o  (head),
    .valid_o (head_vld),
    .room_o  (room)
  );

  assign m_axis_tvalid_o = head_vld;
  assign m_axis_tdata_o  = {5'b00000, head.cause, head.data};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;

  // Once the header is in, the frame never runs past its length plus CRC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.fo >= FW'(2)) |-> (17'(st_q.fo) <= ({1'b0, st_q.len} + 17'd2)))
    else $error("frame offset beyond declared length");

  // A verdict is always the only result of its character, so it carries tlast.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != nlip_pkg::KIND_DATA) |-> m_axis_tlast_o)
    else $error("verdict result not marked last");

  // A processed newline starts a fresh line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q == nlip_pkg::NEWLINE) |=> (pos_q == '0 && cnt_q == 2'd0))
    else $error("line state not cleared at newline");

endmodule
